### hw/rtl/rrtt_pkg.sv
// Shared types, codes and defaults for the round-robin task table.
package rrtt_pkg;

	localparam int SLOTS_DEF       = 16;
	localparam int HANDLE_BITS_DEF = 32;
	localparam int PAYLOAD_BITS    = 32;
	localparam int OPCODE_BITS     = 2;
	localparam int STATUS_BITS     = 2;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_ADD   = 2'd0,
		OP_KILL  = 2'd1,
		OP_NEXT  = 2'd2,
		OP_CHECK = 2'd3
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 2'd0,
		ST_NONE    = 2'd1,
		ST_BAD_ID  = 2'd2,
		ST_PRESENT = 2'd3
	} st_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_NEXT_RD,
		S_CHK_SCAN,
		S_CHK_END
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // latch the transaction fields
		logic exec;       // decode and act on the latched operation
		logic next_cap;   // table read for next has returned
		logic scan_step;  // issue one read of the handle scan
		logic chk_end;    // last compare of the scan, post the result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic chk_fast;   // check of handle zero, settled from occupancy
		logic next_hit;   // next found an occupied slot
		logic scan_last;  // scan counter on the last slot
	} stat_t;

endpackage

### hw/rtl/rrtt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rrtt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/rrtt_ctrl.sv
// Controller state machine sequencing each operation of the task table.
module rrtt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rrtt_pkg::stat_t stat,
	output rrtt_pkg::cmd_t  cmd,
	output logic           busy
);

	rrtt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrtt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrtt_pkg::S_IDLE: begin
				if (start) begin
					state_d = rrtt_pkg::S_EXEC;
				end
			end
			rrtt_pkg::S_EXEC: begin
				unique case (stat.op)
					rrtt_pkg::OP_ADD, rrtt_pkg::OP_KILL: begin
						state_d = rrtt_pkg::S_IDLE;
					end
					rrtt_pkg::OP_NEXT: begin
						state_d = stat.next_hit ? rrtt_pkg::S_NEXT_RD : rrtt_pkg::S_IDLE;
					end
					rrtt_pkg::OP_CHECK: begin
						state_d = stat.chk_fast ? rrtt_pkg::S_IDLE : rrtt_pkg::S_CHK_SCAN;
					end
				endcase
			end
			rrtt_pkg::S_NEXT_RD: begin
				state_d = rrtt_pkg::S_IDLE;
			end
			rrtt_pkg::S_CHK_SCAN: begin
				if (stat.scan_last) begin
					state_d = rrtt_pkg::S_CHK_END;
				end
			end
			rrtt_pkg::S_CHK_END: begin
				state_d = rrtt_pkg::S_IDLE;
			end
			default: begin
				state_d = rrtt_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			rrtt_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			rrtt_pkg::S_EXEC:     cmd.exec      = 1'b1;
			rrtt_pkg::S_NEXT_RD:  cmd.next_cap  = 1'b1;
			rrtt_pkg::S_CHK_SCAN: cmd.scan_step = 1'b1;
			rrtt_pkg::S_CHK_END:  cmd.chk_end   = 1'b1;
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

### hw/rtl/rrtt_dp.sv
// Datapath: slot table memory, occupancy bits, round-robin pointer, result registers.
module rrtt_dp #(
	parameter int SLOTS       = rrtt_pkg::SLOTS_DEF,
	parameter int HANDLE_BITS = rrtt_pkg::HANDLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [rrtt_pkg::OPCODE_BITS-1:0]  opcode,
	input  logic [HANDLE_BITS-1:0]            handle,
	input  logic [rrtt_pkg::PAYLOAD_BITS-1:0] payload,
	input  logic [$clog2(SLOTS+1)-1:0]        task_id,
	input  rrtt_pkg::cmd_t                    cmd,
	output rrtt_pkg::stat_t                   stat,
	output logic                              done,
	output logic [rrtt_pkg::STATUS_BITS-1:0]  status,
	output logic [$clog2(SLOTS)-1:0]          slot,
	output logic [HANDLE_BITS-1:0]            out_handle,
	output logic [rrtt_pkg::PAYLOAD_BITS-1:0] out_payload
);

	localparam int SW = $clog2(SLOTS);
	localparam int IW = $clog2(SLOTS+1);
	localparam int PW = rrtt_pkg::PAYLOAD_BITS;
	localparam int RW = HANDLE_BITS + PW;

	// latched transaction
	rrtt_pkg::op_t     op_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [PW-1:0]     payload_q;
	logic [IW-1:0]     id_q;

	// table state
	logic [SLOTS-1:0]  occ_q;
	logic [SW-1:0]     cur_q;
	logic              cur_valid_q;

	// handle scan
	logic [SW-1:0]     cnt_q;
	logic              chk_s1;
	logic              hit_q;

	// results
	logic              done_q;
	rrtt_pkg::st_t     status_q;
	logic [SW-1:0]     slot_q;
	logic [HANDLE_BITS-1:0] oh_q;
	logic [PW-1:0]     opl_q;

	// memory
	logic              ram_we;
	logic              ram_re;
	logic [SW-1:0]     ram_raddr;
	logic [RW-1:0]     ram_rdata;
	logic [HANDLE_BITS-1:0] rd_handle;
	logic [PW-1:0]     rd_payload;

	// combinational
	logic              free_found;
	logic [SW-1:0]     free_idx;
	logic [SW-1:0]     next_base;
	logic              next_found;
	logic [SW-1:0]     next_idx;
	logic              id_ok;
	logic [SW-1:0]     kill_idx;
	logic [IW-1:0]     id_m1;
	logic              h_zero;
	logic              h_eq;
	logic              fin;
	rrtt_pkg::st_t     res_status;
	logic [SW-1:0]     res_slot;
	logic [HANDLE_BITS-1:0] res_h;
	logic [PW-1:0]     res_p;

	assign rd_handle  = ram_rdata[RW-1:PW];
	assign rd_payload = ram_rdata[PW-1:0];
	assign h_zero     = (handle_q == '0);
	assign h_eq       = (rd_handle == handle_q);
	assign id_ok      = (id_q != '0) && (id_q <= IW'(SLOTS));
	assign id_m1      = id_q - IW'(1);
	assign kill_idx   = id_m1[SW-1:0];

	// lowest empty slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!occ_q[i] && !free_found) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	// round-robin search starting after the current slot, or at slot zero if none is valid
	assign next_base = (!cur_valid_q || cur_q == SW'(SLOTS-1)) ? '0 : cur_q + SW'(1);

	always_comb begin
		logic [SW:0] j;
		next_found = 1'b0;
		next_idx   = '0;
		for (int k = 0; k < SLOTS; k++) begin
			j = {1'b0, next_base} + (SW+1)'(k);
			if (j >= (SW+1)'(SLOTS)) begin
				j = j - (SW+1)'(SLOTS);
			end
			if (occ_q[j[SW-1:0]] && !next_found) begin
				next_found = 1'b1;
				next_idx   = j[SW-1:0];
			end
		end
	end

	assign stat.op        = op_q;
	assign stat.chk_fast  = h_zero;
	assign stat.next_hit  = next_found;
	assign stat.scan_last = (cnt_q == SW'(SLOTS-1));

	assign ram_we    = cmd.exec && (op_q == rrtt_pkg::OP_ADD) && free_found;
	assign ram_re    = cmd.exec || cmd.scan_step;
	assign ram_raddr = cmd.scan_step ? cnt_q : next_idx;

	rrtt_ram #(
		.WIDTH (RW),
		.DEPTH (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx),
		.wdata ({handle_q, payload_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result select
	always_comb begin
		fin        = 1'b0;
		res_status = rrtt_pkg::ST_OK;
		res_slot   = '0;
		res_h      = '0;
		res_p      = '0;
		if (cmd.exec) begin
			unique case (op_q)
				rrtt_pkg::OP_ADD: begin
					fin = 1'b1;
					if (free_found) begin
						res_slot = free_idx;
					end else begin
						res_status = rrtt_pkg::ST_NONE;
					end
				end
				rrtt_pkg::OP_KILL: begin
					fin = 1'b1;
					if (!id_ok) begin
						res_status = rrtt_pkg::ST_BAD_ID;
					end
				end
				rrtt_pkg::OP_NEXT: begin
					if (!next_found) begin
						fin        = 1'b1;
						res_status = rrtt_pkg::ST_NONE;
					end
				end
				rrtt_pkg::OP_CHECK: begin
					// handle zero matches any empty slot
					if (h_zero) begin
						fin = 1'b1;
						if (!(&occ_q)) begin
							res_status = rrtt_pkg::ST_PRESENT;
						end
					end
				end
			endcase
		end
		if (cmd.next_cap) begin
			fin      = 1'b1;
			res_slot = cur_q;
			res_h    = rd_handle;
			res_p    = rd_payload;
		end
		if (cmd.chk_end) begin
			fin = 1'b1;
			if (hit_q || (chk_s1 && h_eq)) begin
				res_status = rrtt_pkg::ST_PRESENT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= rrtt_pkg::OP_ADD;
			occ_q       <= '0;
			cur_q       <= '0;
			cur_valid_q <= 1'b1;
			cnt_q       <= '0;
			chk_s1      <= 1'b0;
			hit_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= fin;
			chk_s1 <= cmd.scan_step && occ_q[cnt_q];
			if (cmd.load) begin
				op_q <= rrtt_pkg::op_t'(opcode);
			end
			if (cmd.scan_step) begin
				cnt_q <= cnt_q + SW'(1);
			end
			if (cmd.exec) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else if (chk_s1 && h_eq) begin
				hit_q <= 1'b1;
			end
			if (ram_we) begin
				occ_q[free_idx] <= !h_zero;
			end
			if (cmd.exec && op_q == rrtt_pkg::OP_KILL && id_ok) begin
				occ_q[kill_idx] <= 1'b0;
			end
			if (cmd.exec && op_q == rrtt_pkg::OP_NEXT) begin
				cur_valid_q <= next_found;
				if (next_found) begin
					cur_q <= next_idx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			handle_q  <= handle;
			payload_q <= payload;
			id_q      <= task_id;
		end
		if (fin) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			oh_q     <= res_h;
			opl_q    <= res_p;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign out_handle  = oh_q;
	assign out_payload = opl_q;

endmodule

### hw/rtl/round_robin_task_table_unit.sv
// Top level of the round-robin task table: controller, datapath and checks.
//
// Channel   Direction  Handshake           Fields
// command   in         start & !busy       opcode, handle, payload, task_id
// result    out        done (one cycle)    status, slot, out_handle, out_payload
//
// Ordering: one result transaction per command transaction, strobed by done. Add,
// kill, next with no task and check of handle zero finish in the execute state;
// next that finds a task adds a read state; check of a nonzero handle reads every
// slot's handle from the table memory, one slot per cycle through its single read
// port, then posts the result from an end state.
// Reset: clears occupancy bits (table empty), current slot zero and valid; the
// memory keeps stale contents, masked by the occupancy bits, so there is no
// clearing pass.
// Stalls: busy is high from the command transaction until the result is
// registered; the receiver cannot stall, done lasts exactly one cycle.
module round_robin_task_table_unit #(
	parameter int SLOTS       = rrtt_pkg::SLOTS_DEF,
	parameter int HANDLE_BITS = rrtt_pkg::HANDLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [rrtt_pkg::OPCODE_BITS-1:0]  opcode,
	input  logic [HANDLE_BITS-1:0]            handle,
	input  logic [rrtt_pkg::PAYLOAD_BITS-1:0] payload,
	input  logic [$clog2(SLOTS+1)-1:0]        task_id,
	output logic                              done,
	output logic [rrtt_pkg::STATUS_BITS-1:0]  status,
	output logic [$clog2(SLOTS)-1:0]          slot,
	output logic [HANDLE_BITS-1:0]            out_handle,
	output logic [rrtt_pkg::PAYLOAD_BITS-1:0] out_payload
);

	rrtt_pkg::cmd_t  cmd;
	rrtt_pkg::stat_t stat;

	// sequencing: one operation in flight at a time
	rrtt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table storage, searches and result registers
	rrtt_dp #(
		.SLOTS       (SLOTS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode      (opcode),
		.handle      (handle),
		.payload     (payload),
		.task_id     (task_id),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.status      (status),
		.slot        (slot),
		.out_handle  (out_handle),
		.out_payload (out_payload)
	);

	// a taken command keeps the block busy until its result is registered
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command taken but block not busy");

	// each result is registered from a busy cycle
	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without work in flight");

	// no operation finishes in two consecutive cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	// only a successful next returns a task handle
	a_handle_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != rrtt_pkg::ST_OK) |-> (out_handle == '0))
		else $error("handle returned with a failing status");

endmodule

### bench/round_robin_task_table_checker.sv
`timescale 1ns / 1ps
// Checker for the round-robin task table: predicts every result transaction and compares it.
module round_robin_task_table_checker #(
	parameter int SLOTS       = rrtt_pkg::SLOTS_DEF,
	parameter int HANDLE_BITS = rrtt_pkg::HANDLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [rrtt_pkg::OPCODE_BITS-1:0]  opcode,
	input  logic [HANDLE_BITS-1:0]            handle,
	input  logic [rrtt_pkg::PAYLOAD_BITS-1:0] payload,
	input  logic [$clog2(SLOTS+1)-1:0]        task_id,
	input  logic                              done,
	input  logic [rrtt_pkg::STATUS_BITS-1:0]  status,
	input  logic [$clog2(SLOTS)-1:0]          slot,
	input  logic [HANDLE_BITS-1:0]            out_handle,
	input  logic [rrtt_pkg::PAYLOAD_BITS-1:0] out_payload,
	output int                                outstanding,
	output int                                mismatches
);

	localparam int SW = $clog2(SLOTS);
	localparam int PB = rrtt_pkg::PAYLOAD_BITS;

	typedef struct {
		rrtt_pkg::st_t            status;
		logic [SW-1:0]            slot;
		logic [HANDLE_BITS-1:0]   hnd;
		logic [PB-1:0]            pay;
	} outcome_t;

	logic [HANDLE_BITS-1:0]   task_handle [SLOTS];
	logic [PB-1:0]            task_data [SLOTS];
	logic [SW-1:0]            cur_slot;
	logic                     cur_valid;
	outcome_t                 pending_outcomes[$];
	int                       err_count;

	// one scheduler operation against the shadow table
	function automatic outcome_t schedule_outcome(rrtt_pkg::op_t op, logic [HANDLE_BITS-1:0] h,
			logic [PB-1:0] p, logic [$clog2(SLOTS+1)-1:0] id);
		outcome_t r;
		int       idx;
		bit       found;
		r.status = rrtt_pkg::ST_OK;
		r.slot   = '0;
		r.hnd    = '0;
		r.pay    = '0;
		found    = 1'b0;
		case (op)
			rrtt_pkg::OP_ADD: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && task_handle[i] == '0) begin
						task_handle[i] = h;
						task_data[i]   = p;
						r.slot         = SW'(i);
						found          = 1'b1;
					end
				end
				r.status = found ? rrtt_pkg::ST_OK : rrtt_pkg::ST_NONE;
			end
			rrtt_pkg::OP_KILL: begin
				if (id == 0 || id > SLOTS) begin
					r.status = rrtt_pkg::ST_BAD_ID;
				end else begin
					task_handle[id-1] = '0;
					task_data[id-1]   = '0;
				end
			end
			rrtt_pkg::OP_NEXT: begin
				idx = cur_valid ? int'(cur_slot) : SLOTS - 1;
				for (int i = 0; i < SLOTS; i++) begin
					if (!found) begin
						idx = (idx + 1) % SLOTS;
						found = (task_handle[idx] != '0);
					end
				end
				if (found) begin
					cur_slot  = SW'(idx);
					cur_valid = 1'b1;
					r.slot    = SW'(idx);
					r.hnd     = task_handle[idx];
					r.pay     = task_data[idx];
				end else begin
					cur_valid = 1'b0;
					r.status  = rrtt_pkg::ST_NONE;
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++)
					if (task_handle[i] == h)
						r.status = rrtt_pkg::ST_PRESENT;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				task_handle[i] = '0;
				task_data[i]   = '0;
			end
			cur_slot  = '0;
			cur_valid = 1'b1;
			pending_outcomes.delete();
			err_count = 0;
		end else begin
			if (done) begin
				if (pending_outcomes.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: unexpected result status=%0d slot=%0d handle=%h data=%h",
							$realtime, status, slot, out_handle, out_payload);
				end else begin
					want = pending_outcomes.pop_front();
					if (status !== want.status || slot !== want.slot ||
							out_handle !== want.hnd || out_payload !== want.pay) begin
						err_count++;
						if (err_count <= 10)
							$display("%0t: mismatch exp status=%0d slot=%0d handle=%h data=%h, got status=%0d slot=%0d handle=%h data=%h",
								$realtime, want.status, want.slot, want.hnd, want.pay,
								status, slot, out_handle, out_payload);
					end
				end
			end
			if (start && !busy)
				pending_outcomes.push_back(schedule_outcome(rrtt_pkg::op_t'(opcode), handle,
					payload, task_id));
		end
		outstanding <= pending_outcomes.size();
		mismatches  <= err_count;
	end

endmodule

### bench/round_robin_task_table_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the round-robin task table: stimulus, checker hookup and verdict.
module round_robin_task_table_unit_tb;

	localparam int SLOTS       = 16;
	localparam int HANDLE_BITS = 32;
	localparam int ID_BITS     = $clog2(SLOTS + 1);
	localparam int PB          = rrtt_pkg::PAYLOAD_BITS;
	// slowest item is a check scan of every slot plus a long sender gap; this is many
	// times the worst case for ~1300 transactions
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES      = 25;
	localparam int PHASE_ITEMS = 50;

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [rrtt_pkg::OPCODE_BITS-1:0]   opcode;
	logic [HANDLE_BITS-1:0]             handle;
	logic [PB-1:0]                      payload;
	logic [ID_BITS-1:0]                 task_id;
	logic                               done;
	logic [rrtt_pkg::STATUS_BITS-1:0]   status;
	logic [$clog2(SLOTS)-1:0]           slot;
	logic [HANDLE_BITS-1:0]             out_handle;
	logic [PB-1:0]                      out_payload;
	int                                 outstanding;
	int                                 mismatches;
	int                                 cycles = 0;

	// handles reused across the run so that check hits and duplicate adds happen
	logic [HANDLE_BITS-1:0]     handle_pool [8];

	round_robin_task_table_unit #(
		.SLOTS       (SLOTS),
		.HANDLE_BITS (HANDLE_BITS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.handle      (handle),
		.payload     (payload),
		.task_id     (task_id),
		.done        (done),
		.status      (status),
		.slot        (slot),
		.out_handle  (out_handle),
		.out_payload (out_payload)
	);

	round_robin_task_table_checker #(
		.SLOTS       (SLOTS),
		.HANDLE_BITS (HANDLE_BITS)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.handle      (handle),
		.payload     (payload),
		.task_id     (task_id),
		.done        (done),
		.status      (status),
		.slot        (slot),
		.out_handle  (out_handle),
		.out_payload (out_payload),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: a hung block or a lost result ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("round_robin_task_table_unit_tb NOT OK");
			$finish;
		end
	end

	// Issue one command transaction and hold it until the block takes it
	// (start high, busy low at the edge). start stays high across back-to-back
	// transactions; with a gap it drops once and the sender idles.
	task automatic send_command(rrtt_pkg::op_t op, logic [HANDLE_BITS-1:0] h,
			logic [PB-1:0] p, logic [ID_BITS-1:0] id, int gap);
		start   <= 1'b1;
		opcode  <= op;
		handle  <= h;
		payload <= p;
		task_id <= id;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender holds off until every outstanding result has come back.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [HANDLE_BITS-1:0] pick_handle();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return $urandom_range(0, 1) ? '1 : HANDLE_BITS'(1) << $urandom_range(0, 31);
			2, 3, 4, 5: return handle_pool[$urandom_range(0, 7)];
			default: return HANDLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [ID_BITS-1:0] pick_id();
		// mostly legal ids; the rest covers zero and ids past the table
		if ($urandom_range(0, 9) == 0)
			return ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
		return ID_BITS'($urandom_range(1, SLOTS));
	endfunction

	function automatic int pick_gap(bit no_idle);
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin : stimulus
		int            add_pct;
		bit            no_idle;
		rrtt_pkg::op_t op;
		int            r;
		arst_n  = 1'b0;
		start   = 1'b0;
		opcode  = rrtt_pkg::OP_ADD;
		handle  = '0;
		payload = '0;
		task_id = '0;
		for (int i = 0; i < 8; i++)
			handle_pool[i] = HANDLE_BITS'($urandom);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty table corner cases
		send_command(rrtt_pkg::OP_CHECK, '0, '0, '0, 0);  // zero matches an empty slot
		send_command(rrtt_pkg::OP_CHECK, '1, '0, '0, 1);
		send_command(rrtt_pkg::OP_NEXT, '0, '0, '0, 0);   // nothing found, current goes invalid
		send_command(rrtt_pkg::OP_KILL, '0, '0, '0, 0);   // id zero is rejected
		send_command(rrtt_pkg::OP_KILL, '0, '0, ID_BITS'(SLOTS + 1), 0); // one past the table
		send_command(rrtt_pkg::OP_KILL, '0, '0, '1, 2);   // largest encodable id
		send_command(rrtt_pkg::OP_KILL, '0, '0, ID_BITS'(SLOTS), 0); // last slot, already empty
		send_command(rrtt_pkg::OP_ADD, '1, '1, '0, 0);
		// zero handle leaves the slot empty
		send_command(rrtt_pkg::OP_ADD, '0, PB'(32'ha5a5_5a5a), '0, 0);
		send_command(rrtt_pkg::OP_NEXT, '0, '0, '0, 0);   // scan restarts from slot zero
		send_command(rrtt_pkg::OP_ADD, HANDLE_BITS'(1), '0, '0, 0);
		send_command(rrtt_pkg::OP_NEXT, '0, '0, '0, 0);
		send_command(rrtt_pkg::OP_CHECK, HANDLE_BITS'(1), '0, '0, 0);
		// fill to capacity, then overflow
		for (int i = 0; i < SLOTS - 2; i++)
			send_command(rrtt_pkg::OP_ADD, HANDLE_BITS'($urandom), PB'($urandom), '0, 0);
		send_command(rrtt_pkg::OP_ADD, HANDLE_BITS'(32'h1234_5678), '1, '0, 0); // table full
		send_command(rrtt_pkg::OP_CHECK, '0, '0, '0, 0);  // zero has no empty slot to match
		send_command(rrtt_pkg::OP_NEXT, '0, '0, '0, 0);
		drain_results();

		// random: each phase leans toward adds or kills so occupancy swings
		// between empty and full; some phases run with no sender idling
		for (int ph = 0; ph < PHASES; ph++) begin
			add_pct = (ph == 0) ? 10 : $urandom_range(5, 80);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < add_pct) begin
					op = rrtt_pkg::OP_ADD;
				end else begin
					case ($urandom_range(0, 2))
						0:       op = rrtt_pkg::OP_KILL;
						1:       op = rrtt_pkg::OP_NEXT;
						default: op = rrtt_pkg::OP_CHECK;
					endcase
				end
				send_command(op, pick_handle(), PB'($urandom), pick_id(), pick_gap(no_idle));
			end
			if (ph == PHASES / 2)
				drain_results();
		end

		// wait out the tail, then give a late or spurious result time to show
		drain_results();
		repeat (SLOTS + 8) @(posedge clk);
		if (mismatches == 0) begin
			$display("round_robin_task_table_unit_tb OK");
		end else begin
			$display("round_robin_task_table_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
